### rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

	localparam int unsigned ELEMS = 9;
	localparam int unsigned QBITS = 33;
	localparam int unsigned DET_W = 96;
	localparam int unsigned COF_W = 64;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] val;
		logic               ovf;
	} lane_res_t;

endpackage

### rtl/mi3_front.sv
// Cofactor and determinant pipeline, eight stages.
module mi3_front #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                adv,
	input  logic signed [31:0]  a [9],
	input  logic [30:0]         thr,
	output logic [63:0]         cof_mag [9],
	output logic                cof_neg [9],
	output logic [95:0]         det_mag,
	output logic                det_neg,
	output logic                sing,
	output mi3_pkg::lane_res_t  det_res
);
	import mi3_pkg::*;

	localparam int unsigned F2 = 2 * FRAC_BITS;

	logic signed [31:0] a_s1 [ELEMS];
	logic signed [63:0] pa_s2 [ELEMS];
	logic signed [63:0] pb_s2 [ELEMS];
	logic signed [31:0] col_s2 [3];
	logic signed [64:0] cof_s3 [ELEMS];
	logic signed [31:0] col_s3 [3];
	logic signed [64:0] cof_s4 [ELEMS];
	logic signed [64:0] pl_s4 [3];
	logic signed [64:0] ph_s4 [3];
	logic signed [64:0] cof_s5 [ELEMS];
	logic signed [96:0] prod_s5 [3];
	logic signed [64:0] cof_s6 [ELEMS];
	logic signed [96:0] det_s6;
	logic [63:0]        cmag_s7 [ELEMS];
	logic               cneg_s7 [ELEMS];
	logic [95:0]        dmag_s7;
	logic               dneg_s7;
	logic [63:0]        cmag_s8 [ELEMS];
	logic               cneg_s8 [ELEMS];
	logic [95:0]        dmag_s8;
	logic               dneg_s8;
	logic               sing_s8;
	lane_res_t          dres_s8;

	logic [95:0] thr_sh;
	logic [95:0] dq;
	logic [95:0] dlim;
	logic        dovf;

	// cofactor operand indices: c = a[x]*a[y] - a[z]*a[w]
	localparam int unsigned IX [ELEMS] = '{4, 2, 1, 5, 0, 3, 3, 1, 0};
	localparam int unsigned IY [ELEMS] = '{8, 7, 5, 6, 8, 2, 7, 6, 4};
	localparam int unsigned IZ [ELEMS] = '{5, 1, 2, 3, 2, 0, 4, 0, 3};
	localparam int unsigned IW [ELEMS] = '{7, 8, 4, 8, 6, 5, 6, 7, 1};

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < ELEMS; i++) begin
				a_s1[i]   <= a[i];
				pa_s2[i]  <= a_s1[IX[i]] * a_s1[IY[i]];
				pb_s2[i]  <= a_s1[IZ[i]] * a_s1[IW[i]];
				cof_s3[i] <= 65'(pa_s2[i]) - 65'(pb_s2[i]);
				cof_s4[i] <= cof_s3[i];
				cof_s5[i] <= cof_s4[i];
				cof_s6[i] <= cof_s5[i];
				cneg_s7[i] <= cof_s6[i][64];
				cmag_s7[i] <= cof_s6[i][64] ? 64'(-cof_s6[i]) : cof_s6[i][63:0];
				cmag_s8[i] <= cmag_s7[i];
				cneg_s8[i] <= cneg_s7[i];
			end
			for (int j = 0; j < 3; j++) begin
				col_s2[j]  <= a_s1[3 * j];
				col_s3[j]  <= col_s2[j];
				pl_s4[j]   <= col_s3[j] * $signed({1'b0, cof_s3[j][31:0]});
				ph_s4[j]   <= col_s3[j] * $signed(cof_s3[j][64:32]);
				prod_s5[j] <= $signed({ph_s4[j], 32'd0}) + 97'(pl_s4[j]);
			end
			det_s6  <= prod_s5[0] + prod_s5[1] + prod_s5[2];
			dneg_s7 <= det_s6[96];
			dmag_s7 <= det_s6[96] ? 96'(-det_s6) : det_s6[95:0];
			dmag_s8 <= dmag_s7;
			dneg_s8 <= dneg_s7;
			sing_s8 <= (dmag_s7 == '0) || (dmag_s7 < thr_sh);
			dres_s8 <= '{val: dovf ? (dneg_s7 ? SAT_MIN : SAT_MAX)
				: (dneg_s7 ? -dq[31:0] : dq[31:0]), ovf: dovf};
		end
	end

	always_comb begin
		thr_sh = 96'(thr) << F2;
		dq     = (dmag_s7 >> F2) + 96'(dmag_s7[F2-1]);
		dlim   = dneg_s7 ? 96'h8000_0000 : 96'h7fff_ffff;
		dovf   = dq > dlim;
	end

	assign cof_mag = cmag_s8;
	assign cof_neg = cneg_s8;
	assign det_mag = dmag_s8;
	assign det_neg = dneg_s8;
	assign sing    = sing_s8;
	assign det_res = dres_s8;

endmodule

### rtl/mi3_div_lane.sv
// One division lane: pipelined restoring divide of cofactor by determinant.
module mi3_div_lane #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               adv,
	input  logic [63:0]        cof_mag,
	input  logic               cof_neg,
	input  logic [95:0]        det_mag,
	input  logic               det_neg,
	output mi3_pkg::lane_res_t res
);
	import mi3_pkg::*;

	localparam int unsigned F2 = 2 * FRAC_BITS;
	localparam int unsigned NW = COF_W + F2;
	localparam int unsigned CW = (NW > DET_W + QBITS + 1) ? NW : DET_W + QBITS + 1;

	logic [CW-1:0]    rem_sk  [QBITS+1];
	logic [QBITS-1:0] quo_sk  [QBITS+1];
	logic [DET_W-1:0] dmag_sk [QBITS+1];
	logic             neg_sk  [QBITS+1];
	logic             big_sk  [QBITS+1];
	lane_res_t        res_q;

	logic [CW-1:0] num;
	logic [CW-1:0] rem2;
	logic [QBITS:0] qr;
	logic [QBITS:0] lim;
	logic           sat;

	assign num = CW'(cof_mag) << F2;

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_sk[0]  <= num;
			quo_sk[0]  <= '0;
			dmag_sk[0] <= det_mag;
			neg_sk[0]  <= cof_neg ^ det_neg;
			big_sk[0]  <= (num >> QBITS) >= CW'(det_mag);
		end
	end

	for (genvar j = 1; j <= QBITS; j++) begin : g_step
		localparam int unsigned K = QBITS - j;
		logic [CW-1:0] dsh;
		assign dsh = CW'(dmag_sk[j-1]) << K;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_sk[j-1] >= dsh) begin
					rem_sk[j]    <= rem_sk[j-1] - dsh;
					quo_sk[j]    <= quo_sk[j-1] | (QBITS'(1) << K);
				end else begin
					rem_sk[j]    <= rem_sk[j-1];
					quo_sk[j]    <= quo_sk[j-1];
				end
				dmag_sk[j] <= dmag_sk[j-1];
				neg_sk[j]  <= neg_sk[j-1];
				big_sk[j]  <= big_sk[j-1];
			end
		end
	end

	always_comb begin
		rem2 = rem_sk[QBITS] << 1;
		qr   = {1'b0, quo_sk[QBITS]} + (QBITS+1)'(rem2 >= CW'(dmag_sk[QBITS]));
		lim  = neg_sk[QBITS] ? (QBITS+1)'(33'h0_8000_0000) : (QBITS+1)'(33'h0_7fff_ffff);
		sat  = big_sk[QBITS] || (qr > lim);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.ovf <= sat;
			if (sat)
				res_q.val <= neg_sk[QBITS] ? SAT_MIN : SAT_MAX;
			else
				res_q.val <= neg_sk[QBITS] ? -qr[31:0] : qr[31:0];
		end
	end

	assign res = res_q;

endmodule

### rtl/matrix_inverse_3x3_top.sv
// Top level: 3x3 fixed-point inverse by adjugate, nine division lanes.
//
//  channel | signals                                  | dir
//  in      | in_valid in_ready a00..a22               | input word
//  out     | out_valid out_ready r00..r22 det_out     | result word
//          | singular overflow                        |
//  cfg     | cfg_valid cfg_ready cfg_data             | threshold write
//
// One word per cycle while the pipe is not frozen; 8 determinant stages, then 35 stages in
// each of the nine lanes (input register, one step per quotient bit for 33 bits,
// output register). Reset clears the valid pipe and sets the threshold to 1.
// When out_valid is held against out_ready low the whole pipe freezes; in_ready
// is low only then.
module matrix_inverse_3x3_top #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] a00,
	input  logic signed [31:0] a01,
	input  logic signed [31:0] a02,
	input  logic signed [31:0] a10,
	input  logic signed [31:0] a11,
	input  logic signed [31:0] a12,
	input  logic signed [31:0] a20,
	input  logic signed [31:0] a21,
	input  logic signed [31:0] a22,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] r00,
	output logic signed [31:0] r01,
	output logic signed [31:0] r02,
	output logic signed [31:0] r10,
	output logic signed [31:0] r11,
	output logic signed [31:0] r12,
	output logic signed [31:0] r20,
	output logic signed [31:0] r21,
	output logic signed [31:0] r22,
	output logic signed [31:0] det_out,
	output logic               singular,
	output logic               overflow,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [30:0]        cfg_data
);
	import mi3_pkg::*;

	localparam int unsigned FRONT_LAT = 8;
	localparam int unsigned LANE_LAT  = QBITS + 2;
	localparam int unsigned LAT       = FRONT_LAT + LANE_LAT;

	logic [30:0]        thr_q;
	logic [LAT-1:0]     vld_q;
	logic               adv;
	logic signed [31:0] a [ELEMS];
	logic [63:0]        cof_mag [ELEMS];
	logic               cof_neg [ELEMS];
	logic [95:0]        det_mag;
	logic               det_neg;
	logic               sing;
	lane_res_t          det_res;
	lane_res_t          lane_res [ELEMS];
	logic               sing_sd [LANE_LAT];
	lane_res_t          dres_sd [LANE_LAT];
	logic signed [31:0] r [ELEMS];
	logic               lane_ovf;

	assign adv       = !vld_q[LAT-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 31'd1;
			vld_q <= '0;
		end else begin
			if (cfg_valid)
				thr_q <= cfg_data;
			if (adv)
				vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

	mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.adv     (adv),
		.a       (a),
		.thr     (thr_q),
		.cof_mag (cof_mag),
		.cof_neg (cof_neg),
		.det_mag (det_mag),
		.det_neg (det_neg),
		.sing    (sing),
		.det_res (det_res)
	);

	for (genvar i = 0; i < ELEMS; i++) begin : g_lane
		mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk     (clk),
			.adv     (adv),
			.cof_mag (cof_mag[i]),
			.cof_neg (cof_neg[i]),
			.det_mag (det_mag),
			.det_neg (det_neg),
			.res     (lane_res[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_sd[0] <= sing;
			dres_sd[0] <= det_res;
			for (int k = 1; k < LANE_LAT; k++) begin
				sing_sd[k] <= sing_sd[k-1];
				dres_sd[k] <= dres_sd[k-1];
			end
		end
	end

	// merge: zero on singular, collect saturation from every lane
	always_comb begin
		lane_ovf = 1'b0;
		for (int i = 0; i < ELEMS; i++) begin
			r[i]     = sing_sd[LANE_LAT-1] ? 32'sd0 : lane_res[i].val;
			lane_ovf = lane_ovf | lane_res[i].ovf;
		end
	end

	assign r00      = r[0];
	assign r01      = r[1];
	assign r02      = r[2];
	assign r10      = r[3];
	assign r11      = r[4];
	assign r12      = r[5];
	assign r20      = r[6];
	assign r21      = r[7];
	assign r22      = r[8];
	assign det_out  = dres_sd[LANE_LAT-1].val;
	assign singular = sing_sd[LANE_LAT-1];
	assign overflow = dres_sd[LANE_LAT-1].ovf || (!sing_sd[LANE_LAT-1] && lane_ovf);

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> (r00 == 0) && (r11 == 0) && (r22 == 0) && (r12 == 0))
		else $error("singular result carries nonzero inverse");

	a_sing_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> overflow == dres_sd[LANE_LAT-1].ovf)
		else $error("lane saturation leaked into singular result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q) && $stable(dres_sd[LANE_LAT-1]))
		else $error("pipe moved while stalled");

endmodule

### tb/tb_top.sv
// Self-checking testbench for matrix_inverse_3x3_top against a local predictor.
`timescale 1ns / 100ps

module tb_top;

	localparam int FRAC = 16;
	localparam int LATENCY = 43;
	localparam int CYCLE_LIMIT = 1000000;

	typedef logic [8:0][31:0] matrix_t;

	typedef struct packed {
		logic [8:0][31:0] inv;
		logic [31:0]      det;
		logic             sing;
		logic             ovf;
	} inverse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	matrix_t in_mat = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [8:0][31:0] r;
	logic [31:0] det_out;
	logic singular, overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [30:0] cfg_data = '0;

	logic [30:0] threshold = 31'd1;
	inverse_t expected_q[$];
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int mismatches = 0;
	int cycles = 0;

	always #4 clk = ~clk;

	matrix_inverse_3x3_top #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a00(in_mat[0]), .a01(in_mat[1]), .a02(in_mat[2]),
		.a10(in_mat[3]), .a11(in_mat[4]), .a12(in_mat[5]),
		.a20(in_mat[6]), .a21(in_mat[7]), .a22(in_mat[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.r00(r[0]), .r01(r[1]), .r02(r[2]),
		.r10(r[3]), .r11(r[4]), .r12(r[5]),
		.r20(r[6]), .r21(r[7]), .r22(r[8]),
		.det_out(det_out), .singular(singular), .overflow(overflow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	function automatic logic [32:0] saturate(input logic neg, input logic [127:0] mag);
		if (neg) begin
			if (mag > 128'h8000_0000)
				return {1'b1, 32'h8000_0000};
			return {1'b0, 32'(-mag[31:0])};
		end
		if (mag > 128'h7fff_ffff)
			return {1'b1, 32'h7fff_ffff};
		return {1'b0, mag[31:0]};
	endfunction

	function automatic inverse_t predict_inverse(input matrix_t m);
		logic signed [127:0] e [9];
		logic signed [127:0] c [9];
		logic signed [127:0] det;
		logic [127:0] dm, cm, num, q, rm, thr;
		logic [32:0] s;
		inverse_t res;
		for (int i = 0; i < 9; i++)
			e[i] = {{96{m[i][31]}}, m[i]};
		c[0] = e[4] * e[8] - e[5] * e[7];
		c[1] = e[2] * e[7] - e[1] * e[8];
		c[2] = e[1] * e[5] - e[2] * e[4];
		c[3] = e[5] * e[6] - e[3] * e[8];
		c[4] = e[0] * e[8] - e[2] * e[6];
		c[5] = e[3] * e[2] - e[0] * e[5];
		c[6] = e[3] * e[7] - e[4] * e[6];
		c[7] = e[1] * e[6] - e[0] * e[7];
		c[8] = e[0] * e[4] - e[3] * e[1];
		det = e[0] * c[0] + e[3] * c[1] + e[6] * c[2];
		dm = det[127] ? -det : det;
		thr = {97'b0, threshold} << (2 * FRAC);
		res = '0;
		res.sing = (dm == 0) || (dm < thr);
		for (int i = 0; i < 9; i++) begin
			if (!res.sing) begin
				cm = c[i][127] ? -c[i] : c[i];
				num = cm << (2 * FRAC);
				q = num / dm;
				rm = num % dm;
				if ((rm << 1) >= dm)
					q = q + 1;
				s = saturate(c[i][127] ^ det[127], q);
				res.inv[i] = s[31:0];
				res.ovf = res.ovf | s[32];
			end
		end
		q = (dm >> (2 * FRAC)) + dm[2 * FRAC - 1];
		s = saturate(det[127], q);
		res.det = s[31:0];
		res.ovf = res.ovf | s[32];
		return res;
	endfunction

	task automatic send_matrix(input matrix_t m);
		if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		in_mat <= m;
		do @(posedge clk); while (!in_ready);
		expected_q.insert(expected_q.size(), predict_inverse(m));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [30:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		threshold = v;
	endtask

	function automatic logic [31:0] fx(input int v);
		return 32'(v);
	endfunction

	function automatic matrix_t diag(input logic [31:0] d0, d1, d2);
		matrix_t m;
		m = '0;
		m[0] = d0;
		m[4] = d1;
		m[8] = d2;
		return m;
	endfunction

	function automatic matrix_t random_matrix;
		matrix_t m;
		int kind, span;
		kind = $urandom_range(9);
		span = $urandom_range(20, 14);
		for (int i = 0; i < 9; i++) begin
			case (kind)
				0, 1: begin
					m[i] = $urandom;
				end
				2: begin
					m[i] = fx($signed($urandom_range(65535)) - 32768) <<< $urandom_range(16);
				end
				default: begin
					m[i] = fx($signed($urandom_range((1 << span) - 1)) - (1 << (span - 1)));
				end
			endcase
		end
		if (kind >= 3 && kind <= 6) begin
			m[0] = m[0] + 32'h0004_0000;
			m[4] = m[4] + 32'h0004_0000;
			m[8] = m[8] - 32'h0004_0000;
		end
		if (kind == 7) begin
			m[6] = m[0];
			m[7] = m[1];
			m[8] = m[2];
		end
		return m;
	endfunction

	task automatic test_directed;
		matrix_t m;
		send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		send_matrix('0);
		send_matrix({9{32'h7fff_ffff}});
		send_matrix({9{32'h8000_0000}});
		send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
		send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
		send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
		send_matrix(diag(32'h0000_1000, 32'h0000_1000, 32'h0000_1000));
		send_matrix(diag(32'h0000_8000, 32'h0001_0000, 32'h0000_8000));
		send_matrix(diag(32'h0003_0000, 32'hfffd_0000, 32'h0003_0000));
		send_matrix(diag(32'h0002_0000, 32'h0002_0000, 32'h0000_8000));
		send_matrix(diag(32'h0001_0001, 32'h0001_0000, 32'h0001_0000));
		send_matrix(diag(32'h7fff_ffff, 32'h0000_0001, 32'h0000_0001));
		m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
		     32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
		     32'h0007_0000, 32'h0008_0000, 32'h0009_0000};
		send_matrix(m);
		m[0] = 32'h000a_0000;
		send_matrix(m);
		m = {32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
		     32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
		     32'h0001_0000, 32'h0000_0000, 32'h0000_0000};
		send_matrix(m);
		m = {32'hffff_0000, 32'h0002_0000, 32'h0000_4000,
		     32'h0000_0000, 32'h0003_0000, 32'hfffe_0000,
		     32'h0001_8000, 32'h0000_0000, 32'h0001_0000};
		send_matrix(m);
		drain();
	endtask

	task automatic test_thresholds;
		logic [30:0] levels [5];
		levels = '{31'd0, 31'h7fff_ffff, 31'h0001_0000, 31'd1, 31'h0000_0100};
		foreach (levels[k]) begin
			write_threshold(levels[k]);
			send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
			send_matrix('0);
			send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
			send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0000_ffff));
			send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
			send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
			for (int i = 0; i < 10; i++)
				send_matrix(random_matrix());
			drain();
		end
	endtask

	task automatic test_random(input int count, input int idle, input int stall);
		in_idle_pct = idle;
		out_stall_pct = stall;
		for (int i = 0; i < count; i++)
			send_matrix(random_matrix());
		drain();
	endtask

	always @(posedge clk) begin
		inverse_t got, exp_res;
		cycles <= cycles + 1;
		out_ready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
		if (arst_n && out_valid && out_ready) begin
			got = {r, det_out, singular, overflow};
			if (expected_q.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result word at %0t", $realtime);
			end else begin
				exp_res = expected_q.pop_front();
				if (got !== exp_res) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10) begin
						$display("mismatch at %0t", $realtime);
						for (int i = 0; i < 9; i++)
							if (got.inv[i] !== exp_res.inv[i])
								$display("  r%0d%0d exp %h got %h", i / 3, i % 3,
									exp_res.inv[i], got.inv[i]);
						$display("  det exp %h got %h sing exp %b got %b ovf exp %b got %b",
							exp_res.det, got.det, exp_res.sing, got.sing,
							exp_res.ovf, got.ovf);
					end
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("matrix_inverse_3x3_top verification failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_thresholds();
		write_threshold(31'd1);
		test_random(160, 0, 0);
		test_random(160, 52, 0);
		test_random(160, 0, 52);
		test_random(160, 19, 19);
		test_random(60, 0, 0);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("matrix_inverse_3x3_top verification clean");
		else
			$display("matrix_inverse_3x3_top verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_div_lane.sv
rtl/matrix_inverse_3x3_top.sv
tb/tb_top.sv
